[hdl/ppbp_pkg.sv]
// Shared types, constants and helpers for the paired byte pipe block.
package ppbp_pkg;

  localparam int PAIR_COUNT = 8;
  localparam int RING_DEPTH = 256;

  localparam int PAIR_W    = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
  localparam int PTR_W     = $clog2(RING_DEPTH);
  localparam int FILL_W    = $clog2(RING_DEPTH + 1);
  localparam int ADDR_W    = 1 + PAIR_W + PTR_W;
  localparam int RAM_DEPTH = 2 ** ADDR_W;

  // Ring select bit in the shared byte store.
  localparam logic RING_DOWN = 1'b0;
  localparam logic RING_UP   = 1'b1;

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_M_WRITE = 3'd2,
    CMD_M_READ  = 3'd3,
    CMD_S_WRITE = 3'd4,
    CMD_S_READ  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_PAIR = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NO_FREE  = 3'd4
  } status_t;

  typedef logic [PAIR_W-1:0] pair_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [FILL_W-1:0] fill_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [2:0] pair_index;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] read_byte;
    logic [2:0] alloc_index;
  } out_item_t;

  // Access request toward the byte store.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

  // Per-item outcome handed to the result register.
  typedef struct packed {
    logic [2:0] status;
    logic [2:0] alloc_index;
    logic       rd_ok;
  } result_t;

  function automatic ptr_t next_slot(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

[hdl/ppbp_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module ppbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/ppbp_ctrl.sv]
// Pair table, ring pointers and command decode for the paired byte pipes.
module ppbp_ctrl import ppbp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     go,
  input  in_item_t in_item,
  output ram_req_t ram_req,
  output result_t  result
);

  logic  active_r  [PAIR_COUNT];
  ptr_t  dn_rd_r   [PAIR_COUNT];
  ptr_t  dn_wr_r   [PAIR_COUNT];
  fill_t dn_fill_r [PAIR_COUNT];
  ptr_t  up_rd_r   [PAIR_COUNT];
  ptr_t  up_wr_r   [PAIR_COUNT];
  fill_t up_fill_r [PAIR_COUNT];

  pair_t   pair_sel;
  logic    pair_in;
  logic    pair_act;
  logic    found;
  pair_t   grant;
  logic    do_alloc;
  logic    do_free;
  logic    push_dn;
  logic    pop_dn;
  logic    push_up;
  logic    pop_up;
  status_t status;

  assign pair_sel = PAIR_W'(in_item.pair_index);
  assign pair_in  = 32'(in_item.pair_index) < 32'(PAIR_COUNT);
  assign pair_act = pair_in && active_r[pair_sel];

  // Lowest inactive pair wins.
  always_comb begin
    found = 1'b0;
    grant = '0;
    for (int i = PAIR_COUNT - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        found = 1'b1;
        grant = PAIR_W'(i);
      end
    end
  end

  always_comb begin
    do_alloc = 1'b0;
    do_free  = 1'b0;
    push_dn  = 1'b0;
    pop_dn   = 1'b0;
    push_up  = 1'b0;
    pop_up   = 1'b0;
    status   = ST_OK;
    case (in_item.cmd)
      CMD_ALLOC: begin
        if (found) begin
          do_alloc = 1'b1;
        end else begin
          status = ST_NO_FREE;
        end
      end
      CMD_FREE: begin
        if (pair_in) begin
          do_free = 1'b1;
        end else begin
          status = ST_BAD_PAIR;
        end
      end
      CMD_M_WRITE: begin
        if (!pair_act) begin
          status = ST_BAD_PAIR;
        end else if (dn_fill_r[pair_sel] == FILL_W'(RING_DEPTH)) begin
          status = ST_FULL;
        end else begin
          push_dn = 1'b1;
        end
      end
      CMD_M_READ: begin
        if (!pair_act) begin
          status = ST_BAD_PAIR;
        end else if (up_fill_r[pair_sel] == '0) begin
          status = ST_EMPTY;
        end else begin
          pop_up = 1'b1;
        end
      end
      CMD_S_WRITE: begin
        if (!pair_act) begin
          status = ST_BAD_PAIR;
        end else if (up_fill_r[pair_sel] == FILL_W'(RING_DEPTH)) begin
          status = ST_FULL;
        end else begin
          push_up = 1'b1;
        end
      end
      CMD_S_READ: begin
        if (!pair_act) begin
          status = ST_BAD_PAIR;
        end else if (dn_fill_r[pair_sel] == '0) begin
          status = ST_EMPTY;
        end else begin
          pop_dn = 1'b1;
        end
      end
      default: begin
        status = ST_BAD_PAIR;
      end
    endcase
  end

  always_comb begin
    ram_req.we    = go && (push_dn || push_up);
    ram_req.re    = go && (pop_dn || pop_up);
    ram_req.wdata = in_item.data_byte;
    ram_req.addr  = {RING_DOWN, pair_sel, dn_wr_r[pair_sel]};
    if (push_up) begin
      ram_req.addr = {RING_UP, pair_sel, up_wr_r[pair_sel]};
    end else if (pop_up) begin
      ram_req.addr = {RING_UP, pair_sel, up_rd_r[pair_sel]};
    end else if (pop_dn) begin
      ram_req.addr = {RING_DOWN, pair_sel, dn_rd_r[pair_sel]};
    end
  end

  assign result.status      = status;
  assign result.alloc_index = do_alloc ? 3'(grant) : 3'd0;
  assign result.rd_ok       = pop_dn || pop_up;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAIR_COUNT; i++) begin
        active_r[i]  <= 1'b0;
        dn_rd_r[i]   <= '0;
        dn_wr_r[i]   <= '0;
        dn_fill_r[i] <= '0;
        up_rd_r[i]   <= '0;
        up_wr_r[i]   <= '0;
        up_fill_r[i] <= '0;
      end
    end else if (go) begin
      if (do_alloc) begin
        active_r[grant]  <= 1'b1;
        dn_rd_r[grant]   <= '0;
        dn_wr_r[grant]   <= '0;
        dn_fill_r[grant] <= '0;
        up_rd_r[grant]   <= '0;
        up_wr_r[grant]   <= '0;
        up_fill_r[grant] <= '0;
      end
      if (do_free) begin
        active_r[pair_sel] <= 1'b0;
      end
      if (push_dn) begin
        dn_wr_r[pair_sel]   <= next_slot(dn_wr_r[pair_sel]);
        dn_fill_r[pair_sel] <= dn_fill_r[pair_sel] + 1'b1;
      end
      if (pop_dn) begin
        dn_rd_r[pair_sel]   <= next_slot(dn_rd_r[pair_sel]);
        dn_fill_r[pair_sel] <= dn_fill_r[pair_sel] - 1'b1;
      end
      if (push_up) begin
        up_wr_r[pair_sel]   <= next_slot(up_wr_r[pair_sel]);
        up_fill_r[pair_sel] <= up_fill_r[pair_sel] + 1'b1;
      end
      if (pop_up) begin
        up_rd_r[pair_sel]   <= next_slot(up_rd_r[pair_sel]);
        up_fill_r[pair_sel] <= up_fill_r[pair_sel] - 1'b1;
      end
    end
  end

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.we && ram_req.re))
    else $error("byte store written and read by the same beat");

  a_access_active: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_req.we || ram_req.re) |-> (pair_in && active_r[pair_sel]))
    else $error("ring access on an inactive pair");

  a_grant_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (go && do_alloc) |=> active_r[$past(grant)])
    else $error("granted pair not marked active");

  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    result.rd_ok |-> (result.status == ST_OK && result.alloc_index == 3'd0))
    else $error("read result with bad status or grant");

endmodule

[hdl/pty_pair_byte_pipes.sv]
// Top level of the paired byte pipes: command handshake, byte store and result register.
// For every command beat the pair table and ring pointers are updated and the byte
// store is accessed at the edge that accepts the beat, and the result appears in the
// output register the cycle after, so a new command is accepted in every cycle while
// the result side is not stalled. Both rings of all pairs live in one byte RAM with one
// write and one registered read port; each command makes at most one access to it, which
// sets the rate at one command per clock while not stalled. Reset clears the pair table
// and pointers; ring bytes are only read after they have been written.
module pty_pair_byte_pipes import ppbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic       go;
  ram_req_t   ram_req;
  result_t    result;
  logic [7:0] ram_q;

  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [2:0] status_r;
  logic [2:0] alloc_r;
  logic       rd_ok_r;

  // The result register is free when empty or drained this cycle.
  assign in_stall = out_valid_r && out_stall;
  assign go       = in_valid && !in_stall;

  ppbp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .in_item (in_item),
    .ram_req (ram_req),
    .result  (result)
  );

  ppbp_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.addr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.addr),
    .rdata (ram_q)
  );

  assign out_valid_nxt = go || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      status_r <= result.status;
      alloc_r  <= result.alloc_index;
      rd_ok_r  <= result.rd_ok;
    end
  end

  // The RAM read data is held because no read is issued while the result waits.
  assign out_valid            = out_valid_r;
  assign out_item.status      = status_r;
  assign out_item.alloc_index = alloc_r;
  assign out_item.read_byte   = rd_ok_r ? ram_q : 8'd0;

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with an empty result register");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid_r)
    else $error("accepted beat produced no result");

  a_read_data_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && rd_ok_r) |=> $stable(ram_q))
    else $error("read byte changed under a stalled result");

endmodule

[verif/tb.sv]
// Self-checking testbench for the paired byte pipes: command beats in, one status beat out each.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppbp_pkg::*;

  // Command codes that the block must reject.
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PRINT_LIMIT = 40;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  pty_pair_byte_pipes i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Shadow copy of the pair table and both rings of every pair.
  logic        pair_live  [PAIR_COUNT];
  logic [7:0]  ring_bytes [2][PAIR_COUNT][RING_DEPTH];
  ptr_t        ring_rd    [2][PAIR_COUNT];
  ptr_t        ring_wr    [2][PAIR_COUNT];
  fill_t       ring_fill  [2][PAIR_COUNT];

  out_item_t   pipe_expect [$];
  out_item_t   last_expect;
  out_item_t   want;
  int unsigned fail_count = 0;
  int unsigned beats_sent = 0;
  int unsigned results_seen = 0;
  int unsigned status_seen [8];
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected.", cycles,
               pipe_expect.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) begin
      $display("MISMATCH at cycle %0d: %s", cycles, msg);
    end
  endtask

  function automatic void clear_shadow();
    for (int p = 0; p < PAIR_COUNT; p++) begin
      pair_live[p] = 1'b0;
      for (int r = 0; r < 2; r++) begin
        ring_rd[r][p]   = '0;
        ring_wr[r][p]   = '0;
        ring_fill[r][p] = '0;
      end
    end
  endfunction

  function automatic status_t push_ring(input int r, input int p, input logic [7:0] b);
    if (ring_fill[r][p] >= fill_t'(RING_DEPTH)) begin
      return ST_FULL;
    end
    ring_bytes[r][p][ring_wr[r][p]] = b;
    ring_wr[r][p] = (ring_wr[r][p] == ptr_t'(RING_DEPTH - 1)) ? '0 : ring_wr[r][p] + 1'b1;
    ring_fill[r][p] = ring_fill[r][p] + 1'b1;
    return ST_OK;
  endfunction

  function automatic status_t pop_ring(input int r, input int p, output logic [7:0] b);
    b = '0;
    if (ring_fill[r][p] == '0) begin
      return ST_EMPTY;
    end
    b = ring_bytes[r][p][ring_rd[r][p]];
    ring_rd[r][p] = (ring_rd[r][p] == ptr_t'(RING_DEPTH - 1)) ? '0 : ring_rd[r][p] + 1'b1;
    ring_fill[r][p] = ring_fill[r][p] - 1'b1;
    return ST_OK;
  endfunction

  // Applies one command to the shadow state and returns the result beat it must produce.
  function automatic out_item_t predict_pipe_op(input in_item_t it);
    out_item_t  r;
    int         p;
    logic       granted;
    logic [7:0] b;
    r = '0;
    r.status = ST_OK;
    p = it.pair_index;
    if (it.cmd == CMD_ALLOC) begin
      granted = 1'b0;
      r.status = ST_NO_FREE;
      for (int i = 0; i < PAIR_COUNT; i++) begin
        if (!granted && !pair_live[i]) begin
          granted = 1'b1;
          pair_live[i] = 1'b1;
          for (int k = 0; k < 2; k++) begin
            ring_rd[k][i]   = '0;
            ring_wr[k][i]   = '0;
            ring_fill[k][i] = '0;
          end
          r.status = ST_OK;
          r.alloc_index = 3'(i);
        end
      end
    end else if (it.cmd > CMD_S_READ || p >= PAIR_COUNT) begin
      r.status = ST_BAD_PAIR;
    end else if (it.cmd == CMD_FREE) begin
      pair_live[p] = 1'b0;
    end else if (!pair_live[p]) begin
      r.status = ST_BAD_PAIR;
    end else begin
      case (it.cmd)
        CMD_M_WRITE: r.status = push_ring(RING_DOWN, p, it.data_byte);
        CMD_S_WRITE: r.status = push_ring(RING_UP, p, it.data_byte);
        CMD_M_READ: begin
          r.status = pop_ring(RING_UP, p, b);
          r.read_byte = b;
        end
        default: begin
          r.status = pop_ring(RING_DOWN, p, b);
          r.read_byte = b;
        end
      endcase
    end
    return r;
  endfunction

  // Holds the beat until it is taken, then predicts it and maybe leaves a gap.
  task automatic send_op(input logic [2:0] cmd, input int unsigned pair,
                         input logic [7:0] data);
    in_item_t it;
    it.cmd = cmd;
    it.pair_index = 3'(pair);
    it.data_byte = data;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_expect = predict_pipe_op(it);
    pipe_expect.push_back(last_expect);
    beats_sent++;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pipe_expect.size() != 0);
  endtask

  task automatic set_phase(input int ph);
    case (ph)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 45; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 45; end
      default: begin send_idle_pct = 17; stall_pct = 17; end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      status_seen[out_item.status]++;
      if (pipe_expect.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected, status %0d",
                                  out_item.status));
      end else begin
        want = pipe_expect.pop_front();
        if (out_item.status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, want %0d", results_seen,
                                    out_item.status, want.status));
        if (out_item.read_byte !== want.read_byte)
          report_mismatch($sformatf("result %0d read_byte %02h, want %02h", results_seen,
                                    out_item.read_byte, want.read_byte));
        if (out_item.alloc_index !== want.alloc_index)
          report_mismatch($sformatf("result %0d alloc_index %0d, want %0d", results_seen,
                                    out_item.alloc_index, want.alloc_index));
      end
    end
  end

  task automatic test_rejects();
    send_op(CMD_M_WRITE, 0, 8'hFF);
    send_op(CMD_S_READ, 7, 8'h00);
    send_op(CMD_RSVD_6, 5, 8'h81);
    send_op(CMD_FREE, 3, 8'h00);
  endtask

  task automatic test_alloc_exhaust();
    for (int i = 0; i < PAIR_COUNT; i++) begin
      send_op(CMD_ALLOC, 7, 8'hFF);
    end
    send_op(CMD_ALLOC, 0, 8'h00);
    send_op(CMD_FREE, 5, 8'h00);
    send_op(CMD_ALLOC, 2, 8'h00);
  endtask

  task automatic test_byte_paths();
    send_op(CMD_M_READ, 0, 8'h00);
    send_op(CMD_S_READ, 0, 8'h00);
    send_op(CMD_M_WRITE, 0, 8'h00);
    send_op(CMD_M_WRITE, 0, 8'hFF);
    send_op(CMD_S_READ, 0, 8'h00);
    send_op(CMD_S_READ, 0, 8'h00);
    send_op(CMD_S_WRITE, 7, 8'hA5);
    send_op(CMD_M_READ, 7, 8'h00);
  endtask

  // A freed pair keeps its bytes until the next allocate empties both rings.
  task automatic test_realloc_clears();
    send_op(CMD_S_WRITE, 6, 8'h5A);
    send_op(CMD_FREE, 6, 8'h00);
    send_op(CMD_ALLOC, 0, 8'h00);
    send_op(CMD_M_READ, 6, 8'h00);
    send_op(CMD_RSVD_7, 6, 8'h3C);
  endtask

  // Fills the master-to-slave ring of one pair past capacity, then drains it past empty.
  task automatic test_ring_full();
    int unsigned p;
    set_phase(0);
    send_op(CMD_FREE, 3, 8'h00);
    send_op(CMD_ALLOC, 0, 8'h00);
    p = last_expect.alloc_index;
    set_phase(1);
    for (int i = 0; i <= RING_DEPTH; i++) begin
      send_op(CMD_M_WRITE, p, 8'($urandom_range(0, 255)));
    end
    wait_idle();
    set_phase(2);
    for (int i = 0; i <= RING_DEPTH; i++) begin
      send_op(CMD_S_READ, p, 8'($urandom_range(0, 255)));
    end
    wait_idle();
  endtask

  task automatic test_random_traffic(input int unsigned beats_per_phase);
    int unsigned live [$];
    int unsigned roll;
    int unsigned pair;
    logic [2:0]  cmd;
    for (int ph = 0; ph < 4; ph++) begin
      set_phase(ph);
      for (int unsigned k = 0; k < beats_per_phase; k++) begin
        live.delete();
        for (int i = 0; i < PAIR_COUNT; i++) begin
          if (pair_live[i]) live.push_back(i);
        end
        roll = $urandom_range(0, 99);
        if (roll < 8) cmd = CMD_ALLOC;
        else if (roll < 14) cmd = CMD_FREE;
        else if (roll < 18) cmd = roll[0] ? CMD_RSVD_7 : CMD_RSVD_6;
        else if (roll < 40) cmd = CMD_M_WRITE;
        else if (roll < 62) cmd = CMD_S_WRITE;
        else if (roll < 81) cmd = CMD_M_READ;
        else cmd = CMD_S_READ;
        // Mostly live pairs, so that the rings actually carry bytes.
        if (live.size() != 0 && $urandom_range(0, 9) < 8) begin
          pair = live[$urandom_range(0, live.size() - 1)];
        end else begin
          pair = $urandom_range(0, PAIR_COUNT - 1);
        end
        send_op(cmd, pair, 8'($urandom_range(0, 255)));
      end
      wait_idle();
    end
  endtask

  initial begin
    clear_shadow();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    set_phase(0);
    test_rejects();
    test_alloc_exhaust();
    test_byte_paths();
    test_realloc_clears();
    wait_idle();
    test_ring_full();
    test_random_traffic(100);
    wait_idle();
    repeat (8) @(posedge clk);
    if (pipe_expect.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", pipe_expect.size()));
    end
    $display("Covered %0d command beats and %0d result beats: ok %0d, bad pair %0d, full %0d,",
             beats_sent, results_seen, status_seen[ST_OK], status_seen[ST_BAD_PAIR],
             status_seen[ST_FULL]);
    $display("empty %0d, no free pair %0d; one ring filled to capacity and drained, four idle mixes.",
             status_seen[ST_EMPTY], status_seen[ST_NO_FREE]);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
